@@ rtl/core/fpw_pkg.sv @@
// ----------------------------------------------------------------------------
// fpw_pkg: shared types and constants of the four-level page walker
// Payload structs, page kind codes, entry bit positions and the walk sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package fpw_pkg;

    localparam int STORE_WORDS = 65536;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    localparam int PA_W   = 52;
    localparam int VA_W   = 48;
    localparam int MIDX_W = 16;
    localparam int WORD_W = 64;
    localparam int WIDX_W = PA_W - 2;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    localparam logic MODE_TRANSLATE = 1'b0;
    localparam logic MODE_WRITE     = 1'b1;

    localparam logic [1:0] KIND_4K = 2'd0;
    localparam logic [1:0] KIND_2M = 2'd1;
    localparam logic [1:0] KIND_1G = 2'd2;

    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    typedef struct packed {
        logic              mode;
        logic [VA_W-1:0]   virt_addr;
        logic [MIDX_W-1:0] mem_index;
        logic [WORD_W-1:0] mem_data;
    } in_item_t;

    typedef struct packed {
        logic [PA_W-1:0] phys_addr;
        logic            fault;
        logic [1:0]      page_kind;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } walk_state_t;

endpackage

`default_nettype wire

@@ rtl/core/fpw_ram.sv @@
// ----------------------------------------------------------------------------
// fpw_ram: generic single-port RAM
// One address per cycle, write when we is high, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/four_level_page_walk.sv @@
// ----------------------------------------------------------------------------
// four_level_page_walk: four-level page table walker over a local word store
// Input beats either write one 64-bit word into the table store or translate
// a 48-bit virtual address. A translate beat gives one result beat carrying
// the physical address, a fault flag and the page kind; a write gives none.
// The cfg channel loads the root table base and is always ready. It must be
// written only while the walker is idle.
// A translation issues one table read per cycle on the single store port:
// the first at the accepting cycle, each following one in the cycle that
// checks the entry just read. A result is registered once a leaf entry or a
// fault is found, and no new beat is accepted until the walker is idle again.
// in_stall is high while a walk is in progress or a result is pending. A result waiting on
// out_stall sits in the output register while the next beat is accepted;
// a second result then waits inside the walker until the register drains.
// Reset clears the root base, the sequencer and the output valid flag.
// The store is not cleared; only written words may be walked.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_walk (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [fpw_pkg::PA_W-1:0] cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire fpw_pkg::in_item_t        in_data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output fpw_pkg::out_item_t            out_data
);

    fpw_pkg::walk_state_t state_reg, state_next;
    logic [1:0]                 level_reg, level_next;
    logic [fpw_pkg::VA_W-1:0]   va_reg, va_next;
    logic [fpw_pkg::PA_W-1:0]   root_reg;
    fpw_pkg::out_item_t         pend_reg, pend_next;
    fpw_pkg::out_item_t         out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic                          ram_we;
    logic [fpw_pkg::ADDR_W-1:0]    ram_addr;
    logic [fpw_pkg::WORD_W-1:0]    ram_rdata;

    logic [fpw_pkg::VA_W-1:0]      va_sel;
    logic [1:0]                    lvl_sel;
    logic [8:0]                    idx_sel;
    logic [fpw_pkg::PA_W-1:0]      base_sel;
    logic [fpw_pkg::PA_W:0]        addr_sum;
    logic [fpw_pkg::WIDX_W-1:0]    widx;
    logic                          in_range;
    logic                          wr_in_range;
    logic                          slot_free;
    logic                          accept;
    fpw_pkg::out_item_t            res;
    logic                          entry_fail;
    logic                          entry_leaf;

    fpw_ram #(
        .WIDTH (fpw_pkg::WORD_W),
        .DEPTH (fpw_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_data.mem_data),
        .rdata (ram_rdata)
    );

    // Shared entry address unit: table base plus index times eight.
    always_comb
    begin
        va_sel   = (state_reg == fpw_pkg::ST_IDLE) ? in_data.virt_addr : va_reg;
        lvl_sel  = (state_reg == fpw_pkg::ST_IDLE) ? fpw_pkg::LVL_PML4 : level_reg - 2'd1;
        base_sel = (state_reg == fpw_pkg::ST_IDLE) ? {root_reg[fpw_pkg::PA_W-1:4], 4'b0}
                                                   : {ram_rdata[fpw_pkg::PA_W-1:12], 12'b0};
        unique case (lvl_sel)
            fpw_pkg::LVL_PML4: idx_sel = va_sel[47:39];
            fpw_pkg::LVL_PDPT: idx_sel = va_sel[38:30];
            fpw_pkg::LVL_PD:   idx_sel = va_sel[29:21];
            default:           idx_sel = va_sel[20:12];
        endcase
        addr_sum    = {1'b0, base_sel} + {41'b0, idx_sel, 3'b0};
        widx        = addr_sum[fpw_pkg::PA_W:3];
        in_range    = widx < fpw_pkg::WIDX_W'(fpw_pkg::STORE_WORDS);
        wr_in_range = 32'(in_data.mem_index) < 32'(fpw_pkg::STORE_WORDS);
    end

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        va_next        = va_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = widx[fpw_pkg::ADDR_W-1:0];
        slot_free      = !out_valid_reg || !out_stall;
        accept         = in_valid && (state_reg == fpw_pkg::ST_IDLE);
        in_stall       = (state_reg != fpw_pkg::ST_IDLE);
        res            = '{phys_addr: '0, fault: 1'b1, page_kind: fpw_pkg::KIND_4K};
        entry_fail     = !ram_rdata[fpw_pkg::BIT_PRESENT]
                         || (level_reg == fpw_pkg::LVL_PML4 && ram_rdata[fpw_pkg::BIT_LARGE]);
        entry_leaf     = (level_reg == fpw_pkg::LVL_PT)
                         || ((level_reg == fpw_pkg::LVL_PDPT || level_reg == fpw_pkg::LVL_PD)
                             && ram_rdata[fpw_pkg::BIT_LARGE]);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fpw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == fpw_pkg::MODE_WRITE)
                    begin
                        ram_we   = wr_in_range;
                        ram_addr = fpw_pkg::ADDR_W'(in_data.mem_index);
                    end
                    else if (root_reg == '0 || !in_range)
                    begin
                        pend_next  = res;
                        state_next = fpw_pkg::ST_DONE;
                    end
                    else
                    begin
                        va_next    = in_data.virt_addr;
                        level_next = fpw_pkg::LVL_PML4;
                        state_next = fpw_pkg::ST_WALK;
                    end
                end
            end
            fpw_pkg::ST_WALK:
            begin
                if (!entry_fail && entry_leaf)
                begin
                    res.fault = 1'b0;
                    unique case (level_reg)
                        fpw_pkg::LVL_PDPT:
                        begin
                            res.phys_addr = {ram_rdata[51:30], va_reg[29:0]};
                            res.page_kind = fpw_pkg::KIND_1G;
                        end
                        fpw_pkg::LVL_PD:
                        begin
                            res.phys_addr = {ram_rdata[51:21], va_reg[20:0]};
                            res.page_kind = fpw_pkg::KIND_2M;
                        end
                        default:
                        begin
                            res.phys_addr = {ram_rdata[51:12], va_reg[11:0]};
                            res.page_kind = fpw_pkg::KIND_4K;
                        end
                    endcase
                end
                if (!entry_fail && !entry_leaf && in_range)
                begin
                    level_next = level_reg - 2'd1;
                end
                else if (slot_free)
                begin
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = fpw_pkg::ST_IDLE;
                end
                else
                begin
                    pend_next  = res;
                    state_next = fpw_pkg::ST_DONE;
                end
            end
            fpw_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = fpw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                root_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        va_reg    <= va_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_translate_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.mode == fpw_pkg::MODE_TRANSLATE)
        |=> (state_reg != fpw_pkg::ST_IDLE))
        else $error("translate beat accepted but walker stayed idle");

    a_fault_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fault)
        |-> (out_data.phys_addr == '0 && out_data.page_kind == fpw_pkg::KIND_4K))
        else $error("faulting result carries a nonzero address or kind");

    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.page_kind == fpw_pkg::KIND_4K
                       || out_data.page_kind == fpw_pkg::KIND_2M
                       || out_data.page_kind == fpw_pkg::KIND_1G))
        else $error("result carries an undefined page kind");

    a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpw_pkg::ST_DONE && !(out_valid_reg && out_stall))
        |=> (state_reg == fpw_pkg::ST_IDLE && out_valid_reg))
        else $error("pending result not moved to the output register");

endmodule

`default_nettype wire
